// ===== design/itrt_pkg.sv =====
// Shared types, constants and helpers for the integer to radix text block.
// Used by itrt_ctrl, itrt_dp and integer_to_radix_text. No dependencies.
package itrt_pkg;

  // Widths fixed by the register and field layout
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int SYM_W      = 8;
  localparam int NUM_SYMS   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Defaults for the top-level parameters
  localparam int DEF_VALUE_BITS = 32;
  localparam int DEF_MAX_BASE   = 16;

  // Dividend bits consumed per divider cycle
  localparam int STEP_BITS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  // Character codes and the printable range allowed for digit symbols
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MIN  = 8'd33;
  localparam logic [SYM_W-1:0] SYM_MAX  = 8'd126;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;       // latch a new value and clear the counters
    logic chk_next;    // move the symbol check to the next symbol
    logic div_step;    // run one divider step
    logic load_sign;   // put the minus sign in the output register
    logic pop;         // read the top of the digit stack
    logic load_digit;  // put the popped digit's symbol in the output register
  } itrt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic chk_fail;    // radix or current symbol is not acceptable
    logic chk_done;    // current symbol is the last one in use
    logic chunk_last;  // this divider cycle finishes one digit
    logic div_end;     // quotient is zero or the stack is full
    logic negative;    // value being converted is negative
    logic stack_empty; // no digits left on the stack
    logic out_free;    // output register can take a new character
  } itrt_stat_t;

  // Pick one symbol byte out of the packed symbol set
  function automatic logic [SYM_W-1:0] sym_byte(
    input logic [NUM_SYMS*SYM_W-1:0] syms,
    input logic [DIGIT_W-1:0]        idx
  );
    sym_byte = syms[idx*SYM_W +: SYM_W];
  endfunction

endpackage

// ===== design/itrt_ctrl.sv =====
// Controller for the integer to radix text block: check, divide, emit.
// Depends on itrt_pkg for the command and status structs.
module itrt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  itrt_pkg::itrt_stat_t  stat,
  output itrt_pkg::itrt_cmd_t   cmd
);
  import itrt_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Accept a new value only when nothing is in progress
  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.chk_fail) begin
          state_next = S_IDLE;
        end else if (stat.chk_done) begin
          state_next = S_DIV;
        end else begin
          cmd.chk_next = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.chunk_last && stat.div_end) begin
          state_next = stat.negative ? S_SIGN : S_POP;
        end
      end
      S_SIGN: begin
        if (stat.out_free) begin
          cmd.load_sign = 1'b1;
          state_next    = S_POP;
        end
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        if (stat.out_free) begin
          cmd.load_digit = 1'b1;
          state_next     = stat.stack_empty ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/itrt_dp.sv =====
// Datapath for the integer to radix text block: symbol check, digit divider,
// digit stack and output register. Depends on itrt_pkg.
module itrt_dp #(
  parameter int VALUE_BITS = itrt_pkg::DEF_VALUE_BITS,
  parameter int MAX_BASE   = itrt_pkg::DEF_MAX_BASE
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic signed [VALUE_BITS-1:0]                  value,
  input  logic [itrt_pkg::RADIX_W-1:0]                  base_size,
  input  logic [itrt_pkg::NUM_SYMS*itrt_pkg::SYM_W-1:0] symbols,
  input  itrt_pkg::itrt_cmd_t                           cmd,
  output itrt_pkg::itrt_stat_t                          stat,
  input  logic                                          out_stall,
  output logic                                          out_valid,
  output logic [itrt_pkg::SYM_W-1:0]                    symbol,
  output logic                                          last
);
  import itrt_pkg::*;

  localparam int CHUNKS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int WORK_W = CHUNKS * STEP_BITS;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int ADDR_W = $clog2(VALUE_BITS);

  logic [DIGIT_W-1:0]    chk_idx;
  logic [SYM_W-1:0]      sym_cur;
  logic [DIGIT_W-1:0]    n_minus;
  logic                  size_bad;
  logic                  sym_bad;
  logic                  dup;

  logic [VALUE_BITS-1:0] v_u;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  negative;
  logic [WORK_W-1:0]     work;
  logic [WORK_W-1:0]     work_t;
  logic [DIGIT_W-1:0]    rem;
  logic [DIGIT_W-1:0]    rem_t;
  logic [RADIX_W-1:0]    rem_w;
  logic [CH_W-1:0]       chunk;
  logic                  chunk_last;
  logic [CNT_W-1:0]      count;
  logic [DIGIT_W-1:0]    stack_mem [VALUE_BITS];
  logic [DIGIT_W-1:0]    rd_data;
  logic                  push;

  // Check one symbol per cycle: range, sign characters and repeats
  assign sym_cur  = sym_byte(symbols, chk_idx);
  assign n_minus  = DIGIT_W'(base_size - RADIX_W'(1));
  assign size_bad = (base_size < RADIX_W'(2)) || (base_size > RADIX_W'(MAX_BASE));
  assign sym_bad  = (sym_cur == CH_PLUS) || (sym_cur == CH_MINUS) ||
                    (sym_cur < SYM_MIN) || (sym_cur > SYM_MAX);

  always_comb begin
    dup = 1'b0;
    for (int b = 0; b < NUM_SYMS; b++) begin
      if ((RADIX_W'(b) > {1'b0, chk_idx}) && (RADIX_W'(b) < base_size) &&
          (sym_byte(symbols, DIGIT_W'(b)) == sym_cur)) begin
        dup = 1'b1;
      end
    end
  end

  // Magnitude of the incoming value, most negative value taken as unsigned
  assign v_u    = value;
  assign mag_in = v_u[VALUE_BITS-1] ? (~v_u + 1'b1) : v_u;

  // Restoring division by the radix, STEP_BITS quotient bits per cycle;
  // quotient bits shift into the low end of the work register
  always_comb begin
    work_t = work;
    rem_t  = rem;
    rem_w  = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      rem_w  = {rem_t, work_t[WORK_W-1]};
      work_t = {work_t[WORK_W-2:0], 1'b0};
      if (rem_w >= base_size) begin
        rem_w     = rem_w - base_size;
        work_t[0] = 1'b1;
      end
      rem_t = rem_w[DIGIT_W-1:0];
    end
  end

  assign chunk_last = (chunk == CH_W'(CHUNKS - 1));
  assign push       = cmd.div_step && chunk_last;

  // Check index, divider and digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_idx  <= '0;
      chunk    <= '0;
      count    <= '0;
      rem      <= '0;
      negative <= 1'b0;
    end else if (cmd.start) begin
      chk_idx  <= '0;
      chunk    <= '0;
      count    <= '0;
      rem      <= '0;
      negative <= v_u[VALUE_BITS-1];
    end else begin
      if (cmd.chk_next) begin
        chk_idx <= chk_idx + 1'b1;
      end
      if (cmd.div_step) begin
        if (chunk_last) begin
          chunk <= '0;
          rem   <= '0;
          count <= count + 1'b1;
        end else begin
          chunk <= chunk + 1'b1;
          rem   <= rem_t;
        end
      end
      if (cmd.pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // Work register: load the magnitude, then hold the running quotient
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      work <= WORK_W'(mag_in);
    end else if (cmd.div_step) begin
      work <= work_t;
    end
  end

  // Digit stack: push the remainder, pop with a registered read
  always_ff @(posedge clk) begin
    if (push) begin
      stack_mem[count[ADDR_W-1:0]] <= rem_t;
    end
    if (cmd.pop) begin
      rd_data <= stack_mem[ADDR_W'(count - 1'b1)];
    end
  end

  // Output register: load a character, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_sign || cmd.load_digit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_sign) begin
      symbol <= CH_MINUS;
      last   <= 1'b0;
    end else if (cmd.load_digit) begin
      symbol <= sym_byte(symbols, rd_data);
      last   <= (count == '0);
    end
  end

  // Status back to the controller
  always_comb begin
    stat.chk_fail    = size_bad || sym_bad || dup;
    stat.chk_done    = (chk_idx == n_minus);
    stat.chunk_last  = chunk_last;
    stat.div_end     = (work_t == '0) || (count == CNT_W'(VALUE_BITS - 1));
    stat.negative    = negative;
    stat.stack_empty = (count == '0);
    stat.out_free    = !out_valid || !out_stall;
  end

endmodule

// ===== design/integer_to_radix_text.sv =====
// Signed integer to text in a configurable radix: top level with the
// configuration registers. Depends on itrt_pkg, itrt_ctrl and itrt_dp.
//
// Usage:
//   Configure base_size (index 0), symbols_low (index 1) and symbols_high
//   (index 2) through write_enable / write_index / write_data while idle.
//   Each value accepted on the input channel (in_valid high, in_stall low)
//   is first checked against the symbol set: radix 2..MAX_BASE, no '+' or
//   '-', every symbol in 33..126 and none repeated. A failed check drops the
//   value with no output. Otherwise the block sends '-' for a negative value,
//   then the digits from most significant to least, one per transfer on the
//   output channel; last marks the final digit.
// Timing:
//   The symbol check steps through the symbols in use one by one (up to
//   16). The divider retires 8 dividend bits per cycle and pushes the
//   digits onto a stack, least significant first. Each character is then
//   read from the stack and loaded into the output register, which waits
//   while the receiver stalls; a minus sign is loaded before the digits.
//   in_stall is high from the transfer of a value until its last
//   character is in the output register or its check fails.
// Reset and stalls:
//   Reset clears the configuration registers, the controller and the output valid flag.
//   While out_stall is high the current character is held unchanged and the
//   block waits before loading another; the final character may still be
//   waiting while the next value is taken in.
module integer_to_radix_text #(
  parameter int VALUE_BITS = itrt_pkg::DEF_VALUE_BITS,
  parameter int MAX_BASE   = itrt_pkg::DEF_MAX_BASE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [itrt_pkg::CFG_IDX_W-1:0]    write_index,
  input  logic [itrt_pkg::CFG_DATA_W-1:0]   write_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [VALUE_BITS-1:0]      value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [itrt_pkg::SYM_W-1:0]        symbol,
  output logic                              last
);
  import itrt_pkg::*;

  logic [RADIX_W-1:0]          base_size;
  logic [CFG_DATA_W-1:0]       symbols_low;
  logic [CFG_DATA_W-1:0]       symbols_high;
  itrt_cmd_t                   cmd;
  itrt_stat_t                  stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_size    <= '0;
      symbols_low  <= '0;
      symbols_high <= '0;
    end else if (write_enable) begin
      unique case (write_index)
        REG_BASE_SIZE:    base_size    <= write_data[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  symbols_low  <= write_data;
        REG_SYMBOLS_HIGH: symbols_high <= write_data;
        default: ;
      endcase
    end
  end

  itrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  itrt_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_BASE   (MAX_BASE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .base_size (base_size),
    .symbols   ({symbols_high, symbols_low}),
    .cmd       (cmd),
    .stat      (stat),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .symbol    (symbol),
    .last      (last)
  );

  // A character is loaded only when the output register is free
  assert property (@(posedge clk) disable iff (rst)
    (cmd.load_sign || cmd.load_digit) |-> (!out_valid || !out_stall))
    else $error("output register overwritten before transfer");

  // A new value starts only on an input transfer
  assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (in_valid && !in_stall))
    else $error("conversion started without an input transfer");

  // The minus sign is never marked last
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_sign |=> (out_valid && !last && symbol == CH_MINUS))
    else $error("minus sign marked last or lost");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for integer_to_radix_text: signed values in, radix text out.
// Needs itrt_pkg and the integer_to_radix_text RTL only; the expected text is
// computed here from the digit set last written to the block.
`timescale 1ns / 1ps

module tb_top;
  import itrt_pkg::*;

  localparam int VBITS        = DEF_VALUE_BITS;
  localparam int MAXB         = DEF_MAX_BASE;
  localparam int SETTLE       = 240;   // worst-case time to drop or finish one value
  localparam int HOLD_CYCLES  = 400;   // long output hold-off
  localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
  localparam int DRAIN_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 240;
  localparam int PHASE_ITEMS  = 30;
  localparam int PRINT_CAP    = 40;

  // Register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Digit sets used by the directed part (symbol 0 in the lowest byte)
  localparam logic [CFG_DATA_W-1:0] DEC_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] DEC_HIGH = 64'hFFFF_FFFF_FFFF_3938;
  localparam logic [CFG_DATA_W-1:0] BIN_LOW  = 64'h2B2D_2020_7F00_3130;
  localparam logic [CFG_DATA_W-1:0] BIN_HIGH = 64'h3131_3131_3131_3131;
  localparam logic [CFG_DATA_W-1:0] HEX_LOW  = 64'h3736_3534_3332_3121;
  localparam logic [CFG_DATA_W-1:0] HEX_HIGH = 64'h7E45_4443_4241_3938;

  typedef struct {
    logic [SYM_W-1:0] sym;
    logic             fin;
  } text_char_t;

  logic                        clk;
  logic                        rst          = 1'b1;
  logic                        write_enable = 1'b0;
  logic [CFG_IDX_W-1:0]        write_index  = REG_BASE_SIZE;
  logic [CFG_DATA_W-1:0]       write_data   = '0;
  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic signed [VBITS-1:0]     value        = '0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic [SYM_W-1:0]            symbol;
  logic                        last;

  // Predictor copy of the registers
  logic [RADIX_W-1:0]          radix_cfg  = '0;
  logic [NUM_SYMS*SYM_W-1:0]   symbol_set = '0;

  logic [VBITS-1:0]            values_to_send[$];
  text_char_t                  expected_text[$];
  int                          items_queued  = 0;
  int                          items_taken   = 0;
  int                          chars_checked = 0;
  int                          errors        = 0;
  int                          set_loads     = 0;
  int                          rejected_sets = 0;
  int                          idle_pct      = 0;
  int                          stall_pct     = 0;
  logic                        hold_req      = 1'b0;
  logic                        hold_on       = 1'b0;

  integer_to_radix_text #(
    .VALUE_BITS(VBITS),
    .MAX_BASE  (MAXB)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .write_index (write_index),
    .write_data  (write_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .last        (last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic logic [SYM_W-1:0] digit_symbol(input int pos);
    return symbol_set[pos*SYM_W +: SYM_W];
  endfunction

  // Radix in range, every symbol printable, no sign characters, no repeats
  function automatic bit digit_set_ok();
    logic [SYM_W-1:0] s;
    if (radix_cfg < 2 || radix_cfg > MAXB) return 1'b0;
    for (int a = 0; a < radix_cfg; a++) begin
      s = digit_symbol(a);
      if (s == CH_PLUS || s == CH_MINUS || s < SYM_MIN || s > SYM_MAX) return 1'b0;
      for (int b = a + 1; b < radix_cfg; b++)
        if (digit_symbol(b) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Expected characters for one value: sign, then digits most significant first
  function automatic void predict_text(input logic [VBITS-1:0] v);
    logic [VBITS-1:0]   mag;
    logic [DIGIT_W-1:0] digs[VBITS];
    int                 n;
    text_char_t         c;
    if (!digit_set_ok()) return;
    mag = v[VBITS-1] ? (~v + 1'b1) : v;
    n = 0;
    do begin
      digs[n] = DIGIT_W'(mag % radix_cfg);
      n++;
      mag = mag / radix_cfg;
    end while (mag != 0 && n < VBITS);
    if (v[VBITS-1]) begin
      c.sym = CH_MINUS;
      c.fin = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.sym = digit_symbol(int'(digs[i]));
      c.fin = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  function automatic logic [VBITS-1:0] random_value();
    case ($urandom_range(7))
      0: return $urandom_range(40);
      1: return -$urandom_range(1, 40);
      2: begin
        case ($urandom_range(3))
          0: return {1'b1, {(VBITS-1){1'b0}}};
          1: return {1'b0, {(VBITS-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    write_enable <= 1'b1;
    write_index  <= idx;
    write_data   <= data;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      REG_BASE_SIZE:    radix_cfg = data[RADIX_W-1:0];
      REG_SYMBOLS_LOW:  symbol_set[CFG_DATA_W-1:0] = data;
      REG_SYMBOLS_HIGH: symbol_set[2*CFG_DATA_W-1:CFG_DATA_W] = data;
      default: ;
    endcase
  endtask

  // Load a full digit set and resume at a falling edge
  task automatic load_digits(input logic [CFG_DATA_W-1:0] radix_word,
                             input logic [CFG_DATA_W-1:0] low,
                             input logic [CFG_DATA_W-1:0] high);
    write_reg(REG_BASE_SIZE, radix_word);
    write_reg(REG_SYMBOLS_LOW, low);
    write_reg(REG_SYMBOLS_HIGH, high);
    set_loads++;
    if (!digit_set_ok()) rejected_sets++;
    @(negedge clk);
  endtask

  // Random distinct printable symbols; now and then break the set on purpose
  task automatic load_random_digits();
    logic [NUM_SYMS*SYM_W-1:0] set;
    logic [SYM_W-1:0]          pool[$];
    logic [SYM_W-1:0]          tmp;
    logic [CFG_DATA_W-1:0]     radix_word;
    int                        r, j, pos;
    for (int c = SYM_MIN; c <= SYM_MAX; c++)
      if (c != CH_PLUS && c != CH_MINUS) pool.push_back(SYM_W'(c));
    r = $urandom_range(2, MAXB);
    for (int k = 0; k < NUM_SYMS; k++) begin
      if (k < r) begin
        j = $urandom_range(k, pool.size() - 1);
        tmp = pool[j];
        pool[j] = pool[k];
        pool[k] = tmp;
        set[k*SYM_W +: SYM_W] = tmp;
      end else begin
        set[k*SYM_W +: SYM_W] = SYM_W'($urandom_range(255));
      end
    end
    if ($urandom_range(6) == 0) begin
      pos = $urandom_range(r - 1);
      case ($urandom_range(3))
        0: set[pos*SYM_W +: SYM_W] = set[((pos + 1) % r)*SYM_W +: SYM_W];
        1: set[pos*SYM_W +: SYM_W] = $urandom_range(1) ? CH_PLUS : CH_MINUS;
        2: set[pos*SYM_W +: SYM_W] = SYM_W'($urandom_range(1) ? $urandom_range(SYM_MIN - 1)
                                                        : $urandom_range(SYM_MAX + 1, 255));
        default: r = $urandom_range(1) ? $urandom_range(1)
                                       : $urandom_range(MAXB + 1, 2**RADIX_W - 1);
      endcase
    end
    // Upper bits of the radix write are junk; only the low field counts
    radix_word = {$urandom(), $urandom()};
    radix_word[RADIX_W-1:0] = RADIX_W'(r);
    load_digits(radix_word, set[CFG_DATA_W-1:0], set[2*CFG_DATA_W-1:CFG_DATA_W]);
  endtask

  task automatic queue_value(input logic [VBITS-1:0] v);
    values_to_send.push_back(v);
    items_queued++;
  endtask

  // Wait for every value to be taken and its text to arrive, then let the block settle
  task automatic finish_phase();
    while (items_taken != items_queued || expected_text.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Input driver: offer queued values, hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_text(value);
        items_taken++;
      end
      if (values_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid <= 1'b1;
        value    <= values_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output monitor: check each transfer against the oldest expected character and drive out_stall
  always @(posedge clk) begin
    text_char_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        chars_checked++;
        if (expected_text.size() == 0) begin
          flag_mismatch($sformatf("unexpected character 0x%02h last %0b", symbol, last));
        end else begin
          want = expected_text.pop_front();
          if (symbol !== want.sym)
            flag_mismatch($sformatf("symbol 0x%02h, expected 0x%02h", symbol, want.sym));
          if (last !== want.fin)
            flag_mismatch($sformatf("last %0b, expected %0b", last, want.fin));
        end
      end
      out_stall <= hold_on || ($urandom_range(99) < stall_pct);
    end
  end

  // Long output hold-off, counted here so the sender keeps pushing meanwhile
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Watchdog: give up after a long stretch with no transfer on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int counted;
    int phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Registers straight out of reset: radix zero, value dropped
    queue_value('0);
    finish_phase();

    // Decimal, with a write to the unused index that must change nothing
    load_digits(10, DEC_LOW, DEC_HIGH);
    write_reg(REG_UNUSED, '1);
    @(negedge clk);
    queue_value(0);
    queue_value(7);
    queue_value(-1);
    queue_value(10);
    queue_value(-10);
    queue_value({1'b0, {(VBITS-1){1'b1}}});
    queue_value({1'b1, {(VBITS-1){1'b0}}});
    finish_phase();

    // Binary: the most negative value gives the longest text
    load_digits(2, BIN_LOW, BIN_HIGH);
    queue_value({1'b1, {(VBITS-1){1'b0}}});
    queue_value({1'b0, {(VBITS-1){1'b1}}});
    queue_value(-1);
    finish_phase();

    // Full radix with the lowest and highest printable symbols
    load_digits(CFG_DATA_W'(MAXB), HEX_LOW, HEX_HIGH);
    queue_value(32'h0F0F_F0F0);
    queue_value(32'h89AB_CDEF);
    finish_phase();

    // Rejected digit sets: each value must vanish without output
    load_digits(1, DEC_LOW, DEC_HIGH);
    queue_value(5);
    finish_phase();
    load_digits(CFG_DATA_W'(MAXB + 1), DEC_LOW, DEC_HIGH);
    queue_value(5);
    finish_phase();
    load_digits('1, DEC_LOW, DEC_HIGH);
    queue_value(-5);
    finish_phase();
    load_digits(10, DEC_LOW, 64'hFFFF_FFFF_FFFF_2B38);
    queue_value(123);
    finish_phase();
    load_digits(10, 64'h3736_3534_3332_312D, DEC_HIGH);
    queue_value(-123);
    finish_phase();
    load_digits(10, 64'h3736_3534_2032_3130, DEC_HIGH);
    queue_value(456);
    finish_phase();
    load_digits(10, 64'h3736_7F34_3332_3130, DEC_HIGH);
    queue_value(456);
    finish_phase();
    load_digits(10, 64'hFF36_3534_3332_3130, DEC_HIGH);
    queue_value(789);
    finish_phase();
    load_digits(10, DEC_LOW, 64'hFFFF_FFFF_FFFF_3038);
    queue_value(789);
    finish_phase();

    // Random digit sets and values, rotating through the idling patterns
    counted = 0;
    phase = 0;
    while (counted < RANDOM_ITEMS) begin
      load_random_digits();
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) queue_value(random_value());
      counted += PHASE_ITEMS;
      // Hold the output off once, on a set that produces text
      if (phase >= 4 && digit_set_ok()) hold_req = 1'b1;
      finish_phase();
      phase++;
    end

    // Drain and wrap up
    for (int i = 0; i < DRAIN_LIMIT && expected_text.size() != 0; i++) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (expected_text.size() != 0)
      flag_mismatch($sformatf("%0d expected characters never arrived", expected_text.size()));
    $display("Converted %0d values over %0d digit sets (%0d rejected), %0d characters checked",
             items_taken, set_loads, rejected_sets, chars_checked);
    $display("Radices 2 to %0d, signed extremes, input gaps, output stalls and a long hold-off",
             MAXB);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
